### sv/tvb_pkg.sv
package tvb_pkg;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SYNC   = 3'd1,
      ST_NO_START   = 3'd2,
      ST_OTHER_PID  = 3'd3,
      ST_BAD_LENGTH = 3'd4,
      ST_TABLE_ID   = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data;
      logic       packet_end;
      status_type status;
   } word_type;

   localparam logic [7:0]  SYNC_BYTE       = 8'h47;
   localparam logic [7:0]  START_FLAG      = 8'h40;
   localparam logic [7:0]  PAT_TABLE_ID    = 8'h00;
   localparam logic [7:0]  PMT_TABLE_ID    = 8'h02;
   localparam logic [9:0]  MAX_SECTION_LEN = 10'd1021;
   localparam logic [1:0]  RESERVED_BITS   = 2'b11;
   localparam logic [12:0] PAT_PID         = 13'd0;

   localparam int OFS_PID_HI   = 1;
   localparam int OFS_PID_LO   = 2;
   localparam int OFS_TABLE_ID = 5;
   localparam int OFS_LEN_HI   = 6;
   localparam int OFS_LEN_LO   = 7;
   localparam int OFS_VERSION  = 10;
   localparam int OFS_MAP_HI   = 15;
   localparam int OFS_MAP_LO   = 16;

endpackage

### sv/tvb_check.sv
module tvb_check import tvb_pkg::*; #(
   parameter int PacketBytes = 188
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data,
   output word_type   word
);

   localparam int PosW = $clog2(PacketBytes);
   localparam logic [PosW-1:0] LAST_POS  = PosW'(PacketBytes - 1);
   localparam logic [PosW-1:0] P_PID_HI  = PosW'(OFS_PID_HI);
   localparam logic [PosW-1:0] P_PID_LO  = PosW'(OFS_PID_LO);
   localparam logic [PosW-1:0] P_TID     = PosW'(OFS_TABLE_ID);
   localparam logic [PosW-1:0] P_LEN_HI  = PosW'(OFS_LEN_HI);
   localparam logic [PosW-1:0] P_LEN_LO  = PosW'(OFS_LEN_LO);
   localparam logic [PosW-1:0] P_VERSION = PosW'(OFS_VERSION);
   localparam logic [PosW-1:0] P_MAP_HI  = PosW'(OFS_MAP_HI);
   localparam logic [PosW-1:0] P_MAP_LO  = PosW'(OFS_MAP_LO);

   logic [PosW-1:0] pos_ff, pos_in;
   status_type      status_ff, status_in;
   logic [4:0]      pid_hi_ff, pid_hi_in;
   logic            is_pat_ff, is_pat_in;
   logic            is_pmt_ff, is_pmt_in;
   logic [1:0]      len_hi_ff, len_hi_in;
   logic [4:0]      map_hi_ff, map_hi_in;
   logic [12:0]     map_pid_ff, map_pid_in;
   logic            map_known_ff, map_known_in;

   status_type status_base;
   logic       base_pat, base_pmt, ok, last;
   logic [12:0] pid;
   logic [9:0]  sec_len;
   logic [4:0]  version;
   logic [7:0]  data_o;

   always_comb begin
      if (pos_ff == '0) begin
         status_base = (data != SYNC_BYTE) ? ST_BAD_SYNC : ST_OK;
         base_pat    = 1'b0;
         base_pmt    = 1'b0;
      end else begin
         status_base = status_ff;
         base_pat    = is_pat_ff;
         base_pmt    = is_pmt_ff;
      end
      ok      = (status_base == ST_OK);
      pid     = {pid_hi_ff, data};
      sec_len = {len_hi_ff, data};
      version = data[5:1] + 5'd1;

      status_in    = status_base;
      is_pat_in    = base_pat;
      is_pmt_in    = base_pmt;
      pid_hi_in    = pid_hi_ff;
      len_hi_in    = len_hi_ff;
      map_hi_in    = map_hi_ff;
      map_pid_in   = map_pid_ff;
      map_known_in = map_known_ff;
      data_o       = data;

      unique case (pos_ff)
         P_PID_HI: begin
            pid_hi_in = data[4:0];
            if (ok && ((data & START_FLAG) == 8'h00)) status_in = ST_NO_START;
         end
         P_PID_LO: begin
            if (ok) begin
               priority if (pid == PAT_PID) is_pat_in = 1'b1;
               else if (map_known_ff && pid == map_pid_ff) is_pmt_in = 1'b1;
               else status_in = ST_OTHER_PID;
            end
         end
         P_TID: begin
            if (ok && data != (base_pat ? PAT_TABLE_ID : PMT_TABLE_ID))
               status_in = ST_TABLE_ID;
         end
         P_LEN_HI: len_hi_in = data[1:0];
         P_LEN_LO: begin
            if (ok && sec_len > MAX_SECTION_LEN) status_in = ST_BAD_LENGTH;
         end
         P_VERSION: begin
            if (ok) data_o = {RESERVED_BITS, version, data[0]};
         end
         P_MAP_HI: begin
            if (ok && base_pat) map_hi_in = data[4:0];
         end
         P_MAP_LO: begin
            if (ok && base_pat) begin
               map_pid_in   = {map_hi_ff, data};
               map_known_in = 1'b1;
            end
         end
         default: ;
      endcase

      last   = (pos_ff == LAST_POS);
      pos_in = last ? '0 : pos_ff + 1'b1;

      word.data       = data_o;
      word.packet_end = last;
      word.status     = last ? status_in : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         status_ff    <= ST_OK;
         pid_hi_ff    <= '0;
         is_pat_ff    <= 1'b0;
         is_pmt_ff    <= 1'b0;
         len_hi_ff    <= '0;
         map_hi_ff    <= '0;
         map_pid_ff   <= '0;
         map_known_ff <= 1'b0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         status_ff    <= status_in;
         pid_hi_ff    <= pid_hi_in;
         is_pat_ff    <= is_pat_in;
         is_pmt_ff    <= is_pmt_in;
         len_hi_ff    <= len_hi_in;
         map_hi_ff    <= map_hi_in;
         map_pid_ff   <= map_pid_in;
         map_known_ff <= map_known_in;
      end
   end

`ifndef SYNTH
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS) else $error("byte position out of range");
   a_one_table: assert property (@(posedge clock) disable iff (reset)
      !(is_pat_ff && is_pmt_ff)) else $error("packet flagged as both tables");
   a_learn_at_map: assert property (@(posedge clock) disable iff (reset)
      $rose(map_known_ff) |-> $past(accept && pos_ff == P_MAP_LO && is_pat_ff))
      else $error("map pid learned outside association table");
`endif

endmodule

### sv/tvb_out.sv
module tvb_out import tvb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  word_type in_word,
   output logic     full,
   output logic     out_valid,
   input  logic     out_stall,
   output word_type out_word
);

   logic     out_vld_ff, out_vld_in;
   logic     skid_vld_ff, skid_vld_in;
   word_type out_ff, out_in;
   word_type skid_ff, skid_in;
   logic     pop;

   assign pop       = out_vld_ff && !out_stall;
   assign full      = skid_vld_ff;
   assign out_valid = out_vld_ff;
   assign out_word  = out_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_vld_ff || pop) begin
            out_in     = in_word;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = in_word;
            skid_vld_in = 1'b1;
         end
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid word without output word");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_vld_ff) else $error("word pushed into full buffer");
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (in_valid && out_vld_ff && out_stall) |=> skid_vld_ff)
      else $error("stalled push not held in skid");
`endif

endmodule

### sv/ts_table_version_bumper.sv
// Each accepted byte is registered in the output register (skid register on stall).
// Throughput: one byte per cycle while req_stall is low; checks are combinational.
// A two-word output buffer keeps req_ open while one result waits on rsp_stall.
// Reset (synchronous): packet alignment restarts at byte 0, learned map PID cleared,
// output buffer emptied.
module ts_table_version_bumper import tvb_pkg::*; #(
   parameter int PACKET_BYTES = 188
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_out,
   output logic       rsp_packet_end,
   output logic [2:0] rsp_status
);

   logic     accept;
   logic     full;
   word_type chk_word;
   word_type rsp_word;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   tvb_check #(.PacketBytes(PACKET_BYTES)) u_check (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .data   (req_data_in),
      .word   (chk_word)
   );

   tvb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (chk_word),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

   assign rsp_data_out   = rsp_word.data;
   assign rsp_packet_end = rsp_word.packet_end;
   assign rsp_status     = rsp_word.status;

endmodule
